// ===== rtl/tdst_pkg.sv =====
// tdst_pkg: shared widths, request codes, register indexes and payload types
// for the touch drag scroll tracker; no dependencies
`timescale 1ns / 1ps

package tdst_pkg;

    localparam int POS_W  = 12;             // touch coordinate width
    localparam int DIF_W  = POS_W + 1;      // signed coordinate difference
    localparam int SCR_W  = 15;             // scroll position width
    localparam int ACC_W  = SCR_W + 2;      // signed scroll sum before clamp
    localparam int CNT_W  = $clog2(POS_W);  // divider step counter
    localparam int REQ_W  = 3;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int MOVE_SLOP_DEF = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_DOWN   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_UP     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_OTHER  = 3'd4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_COL_LIMIT  = 2'd0;
    localparam logic [1:0] REG_COL_WIDTH  = 2'd1;
    localparam logic [1:0] REG_ROW_LIMIT  = 2'd2;
    localparam logic [1:0] REG_ROW_HEIGHT = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [SCR_W-1:0] base_col;
        logic [SCR_W-1:0] base_row;
    } t_in_req;

    typedef struct packed {
        logic             status;
        logic             touching;
        logic             moved;
        logic             tap_done;
        logic [SCR_W-1:0] scroll_col;
        logic [SCR_W-1:0] scroll_row;
    } t_out_res;

endpackage

// ===== rtl/tdst_axis.sv =====
// tdst_axis: one scroll axis; bit-serial restoring divide of the drag distance
// by the item size, then sign fix, subtract from base and clamp; uses tdst_pkg
`timescale 1ns / 1ps

module tdst_axis
    import tdst_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DIF_W-1:0] i_diff,
    input  logic [POS_W-1:0]        i_size,
    input  logic [SCR_W-1:0]        i_base,
    input  logic [SCR_W-1:0]        i_limit,
    output logic                    o_done,
    output logic [SCR_W-1:0]        o_pos
);

    logic             r_busy, r_fin, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [POS_W-1:0] r_dvd;     // dividend bits out at the top, quotient bits in at the bottom
    logic [POS_W-1:0] r_rem;
    logic [POS_W-1:0] r_size;
    logic [SCR_W-1:0] r_base, r_limit, r_pos;

    logic [DIF_W-1:0]        abs_diff;
    logic [DIF_W-1:0]        trial;
    logic [DIF_W-1:0]        sub;
    logic                    ge;
    logic signed [ACC_W-1:0] q_s;
    logic signed [ACC_W-1:0] sum;
    logic [SCR_W-1:0]        clamped;

    assign abs_diff = i_diff[DIF_W-1] ? DIF_W'(-i_diff) : DIF_W'(i_diff);

    assign trial = {r_rem, r_dvd[POS_W-1]};
    assign ge    = trial >= {1'b0, r_size};
    assign sub   = trial - {1'b0, r_size};

    // truncation toward zero: divide magnitudes, then restore the sign
    assign q_s = r_neg ? -$signed({{(ACC_W-POS_W){1'b0}}, r_dvd})
                       :  $signed({{(ACC_W-POS_W){1'b0}}, r_dvd});
    assign sum = $signed({2'b00, r_base}) - q_s;

    always_comb begin
        priority if (r_size == '0) begin
            clamped = r_base;
        end else if (sum[ACC_W-1]) begin
            clamped = '0;
        end else if (sum > $signed({2'b00, r_limit})) begin
            clamped = r_limit;
        end else begin
            clamped = sum[SCR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(POS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg   <= i_diff[DIF_W-1];
            r_dvd   <= abs_diff[POS_W-1:0];
            r_rem   <= '0;
            r_size  <= i_size;
            r_base  <= i_base;
            r_limit <= i_limit;
        end else if (r_busy) begin
            r_rem <= ge ? sub[POS_W-1:0] : trial[POS_W-1:0];
            r_dvd <= {r_dvd[POS_W-2:0], ge};
        end
        if (r_fin) begin
            r_pos <= clamped;
        end
    end

    assign o_done = r_done;
    assign o_pos  = r_pos;

endmodule

// ===== rtl/touch_drag_scroll_tracker_unit.sv =====
// touch_drag_scroll_tracker_unit: top level; touch state, config registers,
// request sequencing and output register; uses tdst_pkg and tdst_axis
`timescale 1ns / 1ps
// Usage:
//   requests enter on i_in_valid / i_in_req and are taken when o_in_stall is low;
//   results leave on o_out_valid / o_out_res and are taken when i_out_stall is low.
//   The configuration registers on the APB-style port, at byte addresses 0, 4, 8
//   and 12 (col_limit, col_width, row_limit, row_height) read back 15/12/15/12 bits.
// Sequencing:
//   the touch state is updated at the accept edge; each axis then runs a bit-serial
//   divider, one quotient bit per cycle, and then a clamp step. The axis results
//   are then loaded into the output register, and the next request can be taken
//   only after that load. The output register lets the next request start while
//   a result waits; if it is still full when the next result is ready, the block
//   holds that result and keeps o_in_stall high until the register frees.
// Reset:
//   synchronous, active low; clears the touch state, the registers, the state and the output valid.

module touch_drag_scroll_tracker_unit
    import tdst_pkg::*;
#(
    parameter int unsigned MOVE_SLOP = MOVE_SLOP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_req           i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_res          o_out_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [SCR_W-1:0] r_col_limit, r_row_limit;
    logic [POS_W-1:0] r_col_width, r_row_height;
    logic [POS_W-1:0] r_cur_x, r_cur_y, r_start_x, r_start_y;
    logic [POS_W-1:0] n_cur_x, n_cur_y, n_start_x, n_start_y;
    logic             r_down, r_moved, r_complete, r_status;
    logic             n_down, n_moved, n_complete;
    logic             r_out_valid;
    t_out_res         r_out_res;

    logic                    in_acc, out_free, is_touch, beyond;
    logic                    col_done, row_done, axes_done, load_out;
    logic [SCR_W-1:0]        col_pos, row_pos;
    logic [DIF_W-1:0]        dx, dy, adx, ady;
    logic signed [DIF_W-1:0] diff_x, diff_y;
    logic                    cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_limit  <= '0;
            r_col_width  <= '0;
            r_row_limit  <= '0;
            r_row_height <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_COL_LIMIT:  r_col_limit  <= pwdata[SCR_W-1:0];
                REG_COL_WIDTH:  r_col_width  <= pwdata[POS_W-1:0];
                REG_ROW_LIMIT:  r_row_limit  <= pwdata[SCR_W-1:0];
                REG_ROW_HEIGHT: r_row_height <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COL_LIMIT:  prdata = DATA_W'(r_col_limit);
            REG_COL_WIDTH:  prdata = DATA_W'(r_col_width);
            REG_ROW_LIMIT:  prdata = DATA_W'(r_row_limit);
            REG_ROW_HEIGHT: prdata = DATA_W'(r_row_height);
            default:        prdata = '0;
        endcase
    end

    // request handshake
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign is_touch   = (i_in_req.req_type <= REQ_OTHER);

    // slop test against the held start point
    assign dx     = {1'b0, i_in_req.pos_x} - {1'b0, r_start_x};
    assign dy     = {1'b0, i_in_req.pos_y} - {1'b0, r_start_y};
    assign adx    = dx[DIF_W-1] ? -dx : dx;
    assign ady    = dy[DIF_W-1] ? -dy : dy;
    assign beyond = (adx > DIF_W'(MOVE_SLOP)) || (ady > DIF_W'(MOVE_SLOP));

    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_start_x  = r_start_x;
        n_start_y  = r_start_y;
        n_down     = r_down;
        n_moved    = r_moved;
        n_complete = r_complete;
        if (in_acc && is_touch) begin
            n_cur_x = i_in_req.pos_x;
            n_cur_y = i_in_req.pos_y;
            unique case (i_in_req.req_type)
                REQ_DOWN: begin
                    n_start_x = i_in_req.pos_x;
                    n_start_y = i_in_req.pos_y;
                    n_down    = 1'b1;
                    n_moved   = 1'b0;
                end
                REQ_UP: begin
                    n_complete = r_down;
                    n_down     = 1'b0;
                end
                REQ_MOVE: begin
                    if (beyond) begin
                        n_moved = 1'b1;
                    end
                end
                REQ_CANCEL: begin
                    n_down     = 1'b0;
                    n_complete = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_down     <= 1'b0;
            r_moved    <= 1'b0;
            r_complete <= 1'b0;
            r_status   <= 1'b0;
        end else begin
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_start_x  <= n_start_x;
            r_start_y  <= n_start_y;
            r_down     <= n_down;
            r_moved    <= n_moved;
            r_complete <= n_complete;
            if (in_acc) begin
                r_status <= ~is_touch;
            end
        end
    end

    // both axes start at the accept edge from the updated points
    assign diff_x = $signed({1'b0, n_cur_x}) - $signed({1'b0, n_start_x});
    assign diff_y = $signed({1'b0, n_cur_y}) - $signed({1'b0, n_start_y});

    tdst_axis u_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_diff  (diff_x),
        .i_size  (r_col_width),
        .i_base  (i_in_req.base_col),
        .i_limit (r_col_limit),
        .o_done  (col_done),
        .o_pos   (col_pos)
    );

    tdst_axis u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_diff  (diff_y),
        .i_size  (r_row_height),
        .i_base  (i_in_req.base_row),
        .i_limit (r_row_limit),
        .o_done  (row_done),
        .o_pos   (row_pos)
    );

    assign axes_done = col_done & row_done;
    assign out_free  = ~r_out_valid | ~i_out_stall;
    assign load_out  = out_free & ((r_state == ST_CALC && axes_done) || r_state == ST_HOLD);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_CALC;
            ST_CALC: if (axes_done) n_state = out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // axis results stay put until the next start, so the hold state can reuse them
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_res.status     <= r_status;
            r_out_res.touching   <= r_down;
            r_out_res.moved      <= r_moved;
            r_out_res.tap_done   <= r_complete;
            r_out_res.scroll_col <= col_pos;
            r_out_res.scroll_row <= row_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

// ===== dv/touch_drag_scroll_tracker_unit_tb.sv =====
// touch_drag_scroll_tracker_unit_tb: self-checking bench for the touch drag scroll
// tracker; tracks tap/drag state and scroll clamping in its own predictor
// depends on tdst_pkg and rtl/touch_drag_scroll_tracker_unit.sv
`timescale 1ns / 1ps

module touch_drag_scroll_tracker_unit_tb
    import tdst_pkg::*;
;

    // request codes beyond the touch set
    localparam logic [REQ_W-1:0] REQ_NON_TOUCH = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_6    = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_7    = 3'd7;

    localparam logic ST_TAKEN   = 1'b0;
    localparam logic ST_IGNORED = 1'b1;

    localparam int POS_MAX     = (1 << POS_W) - 1;
    localparam int SCR_MAX     = (1 << SCR_W) - 1;
    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_req           i_in_req;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_res          o_out_res;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    touch_drag_scroll_tracker_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res  (o_out_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and register copies
    logic [POS_W-1:0] trk_cur_x, trk_cur_y, trk_start_x, trk_start_y;
    logic             trk_down, trk_moved, trk_tap;
    logic [SCR_W-1:0] cfg_col_limit, cfg_row_limit;
    logic [POS_W-1:0] cfg_col_width, cfg_row_height;

    t_out_res pending_results[$];
    int       err_cnt    = 0;
    bit       idle_on    = 1'b1;
    int       stall_left = 0;

    function automatic logic [SCR_W-1:0] drag_pos(input logic [SCR_W-1:0] base,
                                                  input logic [POS_W-1:0] cur,
                                                  input logic [POS_W-1:0] start,
                                                  input logic [POS_W-1:0] size,
                                                  input logic [SCR_W-1:0] limit);
        int diff;
        int steps;
        int pos;
        if (size == 0) return base;
        diff  = int'(cur) - int'(start);
        steps = diff / int'(size);  // truncates toward zero
        pos   = int'(base) - steps;
        if (pos > int'(limit)) pos = int'(limit);
        if (pos < 0) pos = 0;
        return pos[SCR_W-1:0];
    endfunction

    function automatic bit past_slop(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
        int d;
        d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        return d > MOVE_SLOP_DEF;
    endfunction

    function automatic t_out_res track_touch(input t_in_req r);
        t_out_res res;
        if (r.req_type > REQ_OTHER) begin
            res.status = ST_IGNORED;
        end else begin
            res.status = ST_TAKEN;
            trk_cur_x  = r.pos_x;
            trk_cur_y  = r.pos_y;
            case (r.req_type)
                REQ_DOWN: begin
                    trk_start_x = r.pos_x;
                    trk_start_y = r.pos_y;
                    trk_down    = 1'b1;
                    trk_moved   = 1'b0;
                end
                REQ_UP: begin
                    trk_tap  = trk_down;
                    trk_down = 1'b0;
                end
                REQ_MOVE: begin
                    if (past_slop(trk_cur_x, trk_start_x) || past_slop(trk_cur_y, trk_start_y))
                        trk_moved = 1'b1;
                end
                REQ_CANCEL: begin
                    trk_down = 1'b0;
                    trk_tap  = 1'b0;
                end
                default: ;
            endcase
        end
        res.touching   = trk_down;
        res.moved      = trk_moved;
        res.tap_done   = trk_tap;
        res.scroll_col = drag_pos(r.base_col, trk_cur_x, trk_start_x, cfg_col_width,
                                  cfg_col_limit);
        res.scroll_row = drag_pos(r.base_row, trk_cur_y, trk_start_y, cfg_row_height,
                                  cfg_row_limit);
        return res;
    endfunction

    function automatic t_in_req make_req(input logic [REQ_W-1:0] kind, input int x,
                                         input int y, input int bc, input int br);
        t_in_req r;
        r.req_type = kind;
        r.pos_x    = x[POS_W-1:0];
        r.pos_y    = y[POS_W-1:0];
        r.base_col = bc[SCR_W-1:0];
        r.base_row = br[SCR_W-1:0];
        return r;
    endfunction

    // coordinate close to c, kept on the panel
    function automatic int near_pos(input int c, input int span);
        int p;
        p = c + int'($urandom_range(0, 2 * span)) - span;
        if (p < 0) p = 0;
        if (p > POS_MAX) p = POS_MAX;
        return p;
    endfunction

    // one request, sometimes with a random gap in front of it
    task automatic send_req(input t_in_req r);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_req   <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(track_touch(r));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COL_LIMIT:  cfg_col_limit  = value[SCR_W-1:0];
            REG_COL_WIDTH:  cfg_col_width  = value[POS_W-1:0];
            REG_ROW_LIMIT:  cfg_row_limit  = value[SCR_W-1:0];
            REG_ROW_HEIGHT: cfg_row_height = value[POS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input int col_lim, input int col_w, input int row_lim,
                              input int row_h);
        wait_drain();
        write_reg(REG_COL_LIMIT, col_lim);
        write_reg(REG_COL_WIDTH, col_w);
        write_reg(REG_ROW_LIMIT, row_lim);
        write_reg(REG_ROW_HEIGHT, row_h);
    endtask

    // mostly whole gestures (down, moves, up or cancel), some stray requests
    task automatic run_gestures(input int n_items);
        int       sent;
        int       sx, sy, x, y, bc, br, n_moves;
        bit       wide_base;
        t_in_req  r;
        sent = 0;
        while (sent < n_items) begin
            wide_base = ($urandom_range(0, 1) != 0);
            bc = wide_base ? $urandom_range(0, SCR_MAX) : $urandom_range(0, 40);
            br = wide_base ? $urandom_range(0, SCR_MAX) : $urandom_range(0, 40);
            if ($urandom_range(0, 9) < 8) begin
                sx = $urandom_range(0, POS_MAX);
                sy = $urandom_range(0, POS_MAX);
                send_req(make_req(REQ_DOWN, sx, sy, bc, br));
                n_moves = $urandom_range(1, 6);
                for (int i = 0; i < n_moves; i++) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            x = $urandom_range(0, POS_MAX);
                            y = $urandom_range(0, POS_MAX);
                        end
                        1: begin
                            x = near_pos(sx, 400);
                            y = near_pos(sy, 400);
                        end
                        default: begin
                            x = near_pos(sx, 4);
                            y = near_pos(sy, 4);
                        end
                    endcase
                    send_req(make_req(($urandom_range(0, 7) == 0) ? REQ_OTHER : REQ_MOVE,
                                      x, y, bc, br));
                end
                x = near_pos(sx, 600);
                y = near_pos(sy, 600);
                send_req(make_req(($urandom_range(0, 3) == 0) ? REQ_CANCEL : REQ_UP,
                                  x, y, bc, br));
                sent += n_moves + 2;
            end else begin
                r = make_req(REQ_W'($urandom_range(0, 7)), $urandom_range(0, POS_MAX),
                             $urandom_range(0, POS_MAX), bc, br);
                send_req(r);
                sent++;
            end
        end
    endtask

    // registers still at reset: sizes of zero pass the base straight through
    task automatic test_reset_defaults();
        send_req(make_req(REQ_NON_TOUCH, 123, 456, SCR_MAX, 0));
        send_req(make_req(REQ_DOWN, POS_MAX, POS_MAX, SCR_MAX, SCR_MAX));
        send_req(make_req(REQ_MOVE, 0, 0, 12345, 321));
    endtask

    task automatic test_directed_gestures();
        set_config(SCR_MAX, 1, 100, POS_MAX);
        send_req(make_req(REQ_DOWN, POS_MAX, 0, 0, SCR_MAX));
        send_req(make_req(REQ_MOVE, POS_MAX - 2, 2, 0, SCR_MAX));      // right at the slop
        send_req(make_req(REQ_MOVE, POS_MAX - 3, 2, 0, SCR_MAX));      // just past it
        send_req(make_req(REQ_MOVE, 0, POS_MAX, 0, SCR_MAX));
        send_req(make_req(REQ_OTHER, POS_MAX, POS_MAX, SCR_MAX, 0));
        send_req(make_req(REQ_NON_TOUCH, 7, 9, 5, 6));
        send_req(make_req(REQ_RSVD_6, 0, POS_MAX, SCR_MAX, SCR_MAX));
        send_req(make_req(REQ_RSVD_7, POS_MAX, 0, 0, 0));
        send_req(make_req(REQ_UP, 10, 10, 20, 20));
        send_req(make_req(REQ_UP, 11, 11, 20, 20));                   // up with no finger down
        send_req(make_req(REQ_DOWN, 100, 100, 30, 30));
        send_req(make_req(REQ_MOVE, 103, 100, 30, 30));
        send_req(make_req(REQ_CANCEL, 90, 95, 30, 30));
        send_req(make_req(REQ_UP, 90, 95, 30, 30));                   // up after a cancel
        send_req(make_req(REQ_DOWN, 2000, 2000, 50, 50));
        send_req(make_req(REQ_MOVE, 2000, 1998, 50, 50));
        send_req(make_req(REQ_UP, 2001, 1999, 50, 50));
        set_config(0, POS_MAX, 0, 1);
        send_req(make_req(REQ_DOWN, 0, POS_MAX, SCR_MAX, SCR_MAX));
        send_req(make_req(REQ_MOVE, POS_MAX, 0, SCR_MAX, SCR_MAX));
        send_req(make_req(REQ_UP, POS_MAX, 0, 0, 0));
    endtask

    task automatic test_random_settings();
        set_config(0, POS_MAX, 0, POS_MAX);
        run_gestures(90);
        set_config($urandom_range(0, 60), $urandom_range(1, 40), $urandom_range(0, 60),
                   $urandom_range(1, 40));
        run_gestures(90);
        set_config($urandom_range(0, SCR_MAX), 0, $urandom_range(0, SCR_MAX), 0);
        run_gestures(60);
        set_config(SCR_MAX, 1, SCR_MAX, 1);
        run_gestures(90);
    endtask

    // sender holds off until the block has emptied, then carries on
    task automatic test_drain_pause();
        set_config($urandom_range(0, 200), $urandom_range(1, 300), $urandom_range(0, 200),
                   $urandom_range(1, 300));
        run_gestures(20);
        wait_drain();
        run_gestures(20);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        run_gestures(40);
    endtask

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %h", o_out_res);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_res.status);
                    err_cnt++;
                end
                if (o_out_res.touching !== want.touching) begin
                    $error("touching: expected %0d, got %0d", want.touching,
                           o_out_res.touching);
                    err_cnt++;
                end
                if (o_out_res.moved !== want.moved) begin
                    $error("moved: expected %0d, got %0d", want.moved, o_out_res.moved);
                    err_cnt++;
                end
                if (o_out_res.tap_done !== want.tap_done) begin
                    $error("tap_done: expected %0d, got %0d", want.tap_done,
                           o_out_res.tap_done);
                    err_cnt++;
                end
                if (o_out_res.scroll_col !== want.scroll_col) begin
                    $error("scroll_col: expected %0d, got %0d", want.scroll_col,
                           o_out_res.scroll_col);
                    err_cnt++;
                end
                if (o_out_res.scroll_row !== want.scroll_row) begin
                    $error("scroll_row: expected %0d, got %0d", want.scroll_row,
                           o_out_res.scroll_row);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        trk_cur_x      = '0;
        trk_cur_y      = '0;
        trk_start_x    = '0;
        trk_start_y    = '0;
        trk_down       = 1'b0;
        trk_moved      = 1'b0;
        trk_tap        = 1'b0;
        cfg_col_limit  = '0;
        cfg_col_width  = '0;
        cfg_row_limit  = '0;
        cfg_row_height = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_gestures();
        test_random_settings();
        test_drain_pause();
        test_back_to_back();

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tdst_pkg.sv
rtl/tdst_axis.sv
rtl/touch_drag_scroll_tracker_unit.sv
dv/touch_drag_scroll_tracker_unit_tb.sv
